@@ src/dlts_pkg.sv @@
// Package for the delta-list task scheduler: sizes, command and status codes,
// payload structs and the control word broadcast to the entry cells.
// No dependencies.
package dlts_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_DISPATCH = 3'd2;
    localparam logic [2:0] CMD_DELETE   = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic [7:0] RUNS_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_handle;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
        logic [3:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       run_valid;
        logic [7:0] run_handle;
        logic [4:0] slot_index;
        logic [4:0] task_count;
    } t_res;

    // One list entry, held by one cell
    typedef struct packed {
        logic [7:0]  handle;
        logic [31:0] delta;
        logic [31:0] period;
        logic [7:0]  runs;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TICK,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_cell_op;

    // Control word seen by every cell in the same cycle
    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [31:0]      rem;
    } t_cell_ctrl;

endpackage

@@ src/dlts_cell.sv @@
// One entry cell of the delta-list chain: holds one task entry and takes
// data from its left or right neighbour on insert and remove.
// Depends on dlts_pkg.
module dlts_cell
    import dlts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  t_entry           i_new,
    input  t_entry           i_left,
    input  t_entry           i_right,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    logic [CNT_W-1:0] w_idx;
    logic [CNT_W-1:0] w_pos;
    logic [32:0]      w_sum;

    assign w_idx = CNT_W'(i_index);
    assign w_pos = CNT_W'(i_ctrl.pos);
    assign w_sum = {1'b0, i_right.delta} + {1'b0, r_entry.delta};

    // Next entry value for the broadcast operation
    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            OP_TICK: begin
                if (w_idx == '0) begin
                    if (r_entry.delta == '0) begin
                        if (r_entry.runs != RUNS_MAX) begin
                            n_entry.runs = r_entry.runs + 8'd1;
                        end
                    end else begin
                        n_entry.delta = r_entry.delta - 32'd1;
                    end
                end
            end
            OP_INSERT: begin
                if (w_idx > w_pos) begin
                    n_entry = i_left;
                    // successor of the new entry loses the remainder
                    if (w_idx == w_pos + CNT_W'(1) && w_pos < i_ctrl.count) begin
                        n_entry.delta = i_left.delta - i_ctrl.rem;
                    end
                end else if (w_idx == w_pos) begin
                    n_entry       = i_new;
                    n_entry.delta = i_ctrl.rem;
                    n_entry.runs  = '0;
                end
            end
            OP_REMOVE: begin
                if (w_idx >= w_pos) begin
                    n_entry = i_right;
                    // successor keeps its expiry: absorbs the removed delta
                    if (w_idx == w_pos && w_idx + CNT_W'(1) < i_ctrl.count) begin
                        n_entry.delta = w_sum[32] ? '1 : w_sum[31:0];
                    end
                end
            end
            OP_CLEAR: begin
                n_entry = '0;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ src/delta_list_task_scheduler.sv @@
// Top level of the delta-list task scheduler: command sequencer, insertion
// walk and the chain of entry cells.
// Depends on dlts_pkg and dlts_cell.
//
// Usage: drive i_cmd and raise start while busy is low; the command is taken
// at that clock edge. Exactly one result follows on o_res, marked by a
// one-cycle o_valid strobe; the receiver cannot hold it off and must take it.
// Tick, dispatch of a one-shot task, delete, clear, unused codes and rejected commands
// finish in the accepting cycle: busy stays low and the result shows in the
// next cycle, so such commands may be issued every cycle.
// Add walks the list one entry per cycle from the head (state S_WALK), then
// the cells shift and store the new entry (state S_INS); busy stays high
// throughout and the result shows as busy falls. A dispatch that reinserts a
// periodic task costs the same walk. The longest walk passes all 15 entries
// of a list that has room for one more.
// Reset (synchronous, active low) empties the list and drops any command in
// progress; no result is produced for it.
module delta_list_task_scheduler
    import dlts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_INS
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [31:0]      r_rem;
    t_entry           r_new;
    logic             r_add;
    logic             r_run_valid;
    logic [7:0]       r_run_handle;
    logic             r_out_valid;
    t_res             r_res;

    t_state           n_state;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_idx;
    logic [31:0]      n_rem;
    t_entry           n_new;
    logic             n_add;
    logic             n_run_valid;
    logic [7:0]       n_run_handle;
    logic             n_out_valid;
    t_res             n_res;

    t_entry     w_entry [MAX_ENTRIES];
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_disp_ok;
    logic       w_pos_ok;
    logic       w_walk_go;
    logic [31:0] w_walk_delta;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_disp_ok    = (r_count != '0) && (w_entry[0].runs != '0);
    assign w_pos_ok     = CNT_W'(i_cmd.position) < r_count;
    assign w_walk_delta = w_entry[r_idx[IDX_W-1:0]].delta;
    assign w_walk_go    = (r_idx < r_count) && (r_rem >= w_walk_delta);

    // Control word broadcast to the cells
    always_comb begin
        w_ctrl.op    = OP_HOLD;
        w_ctrl.pos   = '0;
        w_ctrl.count = r_count;
        w_ctrl.rem   = r_rem;
        if (r_state == S_IDLE && w_accept) begin
            case (i_cmd.command)
                CMD_TICK: begin
                    if (r_count != '0) begin
                        w_ctrl.op = OP_TICK;
                    end
                end
                CMD_DISPATCH: begin
                    if (w_disp_ok) begin
                        w_ctrl.op = OP_REMOVE;
                    end
                end
                CMD_DELETE: begin
                    if (w_pos_ok) begin
                        w_ctrl.op  = OP_REMOVE;
                        w_ctrl.pos = IDX_W'(i_cmd.position);
                    end
                end
                CMD_CLEAR: begin
                    w_ctrl.op = OP_CLEAR;
                end
                default: begin
                    w_ctrl.op = OP_HOLD;
                end
            endcase
        end else if (r_state == S_INS) begin
            w_ctrl.op  = OP_INSERT;
            w_ctrl.pos = r_idx[IDX_W-1:0];
        end
    end

    // Chain of entry cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        dlts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_new   (r_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g])
        );
    end

    // Sequencer next state: entry count, walk and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rem        = r_rem;
        n_new        = r_new;
        n_add        = r_add;
        n_run_valid  = r_run_valid;
        n_run_handle = r_run_handle;
        n_out_valid  = 1'b0;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res            = '0;
                    n_res.status     = ST_OK;
                    n_res.task_count = 5'(r_count);
                    n_out_valid      = 1'b1;
                    case (i_cmd.command)
                        CMD_TICK: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end
                        end
                        CMD_ADD: begin
                            if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                n_res.status     = ST_FULL;
                                n_res.slot_index = 5'(MAX_ENTRIES);
                            end else begin
                                n_out_valid  = 1'b0;
                                n_new.handle = i_cmd.task_handle;
                                n_new.delta  = '0;
                                n_new.period = i_cmd.period_ticks;
                                n_new.runs   = '0;
                                n_rem        = i_cmd.delay_ticks;
                                n_idx        = '0;
                                n_add        = 1'b1;
                                n_run_valid  = 1'b0;
                                n_run_handle = '0;
                                n_state      = S_WALK;
                            end
                        end
                        CMD_DISPATCH: begin
                            if (!w_disp_ok) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (w_entry[0].period != '0) begin
                                    // periodic: reinsert after the head leaves
                                    n_out_valid  = 1'b0;
                                    n_new.handle = w_entry[0].handle;
                                    n_new.delta  = '0;
                                    n_new.period = w_entry[0].period;
                                    n_new.runs   = '0;
                                    n_rem        = w_entry[0].period;
                                    n_idx        = '0;
                                    n_add        = 1'b0;
                                    n_run_valid  = 1'b1;
                                    n_run_handle = w_entry[0].handle;
                                    n_state      = S_WALK;
                                end else begin
                                    n_res.run_valid  = 1'b1;
                                    n_res.run_handle = w_entry[0].handle;
                                    n_res.task_count = 5'(r_count - CNT_W'(1));
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (!w_pos_ok) begin
                                n_res.status = ST_BADPOS;
                            end else begin
                                n_count          = r_count - CNT_W'(1);
                                n_res.task_count = 5'(r_count - CNT_W'(1));
                            end
                        end
                        CMD_CLEAR: begin
                            n_count          = '0;
                            n_res.task_count = '0;
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // pass one entry per cycle while the delay covers it
                if (w_walk_go) begin
                    n_rem = r_rem - w_walk_delta;
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_count          = r_count + CNT_W'(1);
                n_res.status     = ST_OK;
                n_res.run_valid  = r_run_valid;
                n_res.run_handle = r_run_handle;
                n_res.slot_index = r_add ? 5'(r_idx) : 5'd0;
                n_res.task_count = 5'(r_count + CNT_W'(1));
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_rem        <= n_rem;
        r_new        <= n_new;
        r_add        <= n_add;
        r_run_valid  <= n_run_valid;
        r_run_handle <= n_run_handle;
        r_res        <= n_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

@@ tb/delta_list_task_scheduler_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the delta-list task scheduler: a directed table
// followed by random command streams, each result checked against the table or a list model.
// Depends on dlts_pkg and delta_list_task_scheduler.
module delta_list_task_scheduler_test;
    import dlts_pkg::*;

    // Command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Random command mixes
    localparam int MODE_MIXED = 0;
    localparam int MODE_FILL  = 1;
    localparam int MODE_DRAIN = 2;

    localparam int RANDOM_ITEMS = 360;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        t_cmd item;
        int   reps;
        bit   typed;
        t_res res;
    } t_stim_rec;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    // Scheduler model state
    t_entry task_list[MAX_ENTRIES];
    int     list_len;

    t_res      pending_results[$];
    t_stim_rec stim_rows[$];

    int errors      = 0;
    int n_transfers = 0;
    int n_directed  = 0;
    int n_results   = 0;
    int n_runs      = 0;
    int n_full      = 0;

    delta_list_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic void list_clear();
        for (int i = 0; i < MAX_ENTRIES; i++) task_list[i] = '0;
        list_len = 0;
    endfunction

    // Walks the deltas, opens a slot and shortens the successor's delta
    function automatic logic [4:0] list_insert(logic [7:0] hnd, logic [31:0] dly,
                                               logic [31:0] per);
        int pos;
        int i;
        if (list_len >= MAX_ENTRIES) return 5'(MAX_ENTRIES);
        pos = 0;
        while (pos < list_len && dly >= task_list[pos].delta) begin
            dly -= task_list[pos].delta;
            pos++;
        end
        for (i = list_len; i > pos; i--) task_list[i] = task_list[i - 1];
        if (pos < list_len) task_list[pos + 1].delta -= dly;
        task_list[pos].handle = hnd;
        task_list[pos].delta  = dly;
        task_list[pos].period = per;
        task_list[pos].runs   = '0;
        list_len++;
        return pos[4:0];
    endfunction

    // Removal folds the gone delta into the successor, saturating
    function automatic void list_remove(int pos);
        logic [32:0] sum;
        int i;
        if (pos + 1 < list_len) begin
            sum = {1'b0, task_list[pos + 1].delta} + task_list[pos].delta;
            task_list[pos + 1].delta = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        for (i = pos; i + 1 < list_len; i++) task_list[i] = task_list[i + 1];
        task_list[list_len - 1] = '0;
        list_len--;
    endfunction

    function automatic t_res schedule_step(t_cmd c);
        t_res   r;
        t_entry head;
        r = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_TICK: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (task_list[0].delta == 0) begin
                    if (task_list[0].runs != RUNS_MAX) task_list[0].runs++;
                end else begin
                    task_list[0].delta--;
                end
            end
            CMD_ADD: begin
                r.slot_index = list_insert(c.task_handle, c.delay_ticks, c.period_ticks);
                if (r.slot_index == MAX_ENTRIES) r.status = ST_FULL;
            end
            CMD_DISPATCH: begin
                if (list_len == 0 || task_list[0].runs == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head = task_list[0];
                    r.run_valid  = 1'b1;
                    r.run_handle = head.handle;
                    list_remove(0);
                    // periodic task goes back in, extra runs dropped
                    if (head.period != 0)
                        void'(list_insert(head.handle, head.period, head.period));
                end
            end
            CMD_DELETE: begin
                if (c.position >= list_len) r.status = ST_BADPOS;
                else list_remove(c.position);
            end
            CMD_CLEAR: list_clear();
            default: ;
        endcase
        r.task_count = list_len[4:0];
        return r;
    endfunction

    // ------------------------------------------------------------- stimulus

    function automatic t_res res_of(logic [1:0] st, logic rv, logic [7:0] rh,
                                    logic [4:0] slot, logic [4:0] cnt);
        t_res r;
        r.status     = st;
        r.run_valid  = rv;
        r.run_handle = rh;
        r.slot_index = slot;
        r.task_count = cnt;
        return r;
    endfunction

    task automatic stim_row(input logic [2:0] cmd, input logic [7:0] hnd,
                            input logic [31:0] dly, input logic [31:0] per,
                            input logic [3:0] pos, input int reps,
                            input bit typed, input t_res res);
        t_stim_rec r;
        r.item.command      = cmd;
        r.item.task_handle  = hnd;
        r.item.delay_ticks  = dly;
        r.item.period_ticks = per;
        r.item.position     = pos;
        r.reps  = reps;
        r.typed = typed;
        r.res   = res;
        stim_rows.push_back(r);
    endtask

    function automatic logic [31:0] pick_ticks(int zero_pct);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < zero_pct) return '0;
        if (roll < 60) return $urandom_range(8, 1);
        if (roll < 85) return $urandom_range(200, 0);
        return $urandom;
    endfunction

    // Draws one command; the mode biases towards filling or draining the list
    function automatic t_cmd random_cmd(int mode);
        t_cmd c;
        int roll;
        int w_tick;
        int w_add;
        int w_disp;
        int w_del;
        c.task_handle  = 8'($urandom);
        c.delay_ticks  = pick_ticks(15);
        c.period_ticks = pick_ticks(35);
        c.position     = 4'($urandom);
        case (mode)
            MODE_FILL:  begin w_tick = 15; w_add = 75; w_disp = 85; w_del = 95; end
            MODE_DRAIN: begin w_tick = 55; w_add = 62; w_disp = 90; w_del = 97; end
            default:    begin w_tick = 35; w_add = 60; w_disp = 80; w_del = 93; end
        endcase
        roll = $urandom_range(99, 0);
        if (roll < w_tick)          c.command = CMD_TICK;
        else if (roll < w_add)      c.command = CMD_ADD;
        else if (roll < w_disp)     c.command = CMD_DISPATCH;
        else if (roll < w_del)      c.command = CMD_DELETE;
        else if (roll < w_del + 2)  c.command = CMD_CLEAR;
        else c.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        // mostly aim deletes at live entries
        if (c.command == CMD_DELETE && list_len > 0 && $urandom_range(3, 0) != 0)
            c.position = 4'($urandom_range(list_len - 1, 0));
        return c;
    endfunction

    // Presents one command after a gap, waits for the transfer, books the result
    task automatic send_cmd(input t_cmd item, input int gap, input bit typed,
                            input t_res typed_res);
        t_res pred;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= item;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pred = schedule_step(item);
        pending_results.push_back(typed ? typed_res : pred);
        n_transfers++;
    endtask

    initial begin : stimulus
        t_cmd item;
        int   counted;
        int   k;
        int   mode;
        bit   quiet;
        int   waited;

        list_clear();

        // Directed table: empty-list cases, saturation, full list, extremes
        stim_row(CMD_TICK,     8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_EMPTY, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_EMPTY, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_DELETE,   8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_BADPOS, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_SPARE_HI, 8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_ADD,      8'hFF, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd1));
        // head due but no run counted yet
        stim_row(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_EMPTY, 1'b0, 8'h00, 5'd0, 5'd1));
        // run count saturates well inside 300 ticks
        stim_row(CMD_TICK,     8'h00, 32'h0, 32'h0, 4'h0, 300, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd1));
        stim_row(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b1, 8'hFF, 5'd0, 5'd0));
        stim_row(CMD_ADD,      8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd1));
        // equal expiry goes behind the existing entry
        stim_row(CMD_ADD,      8'h00, 32'hFFFF_FFFF, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd1, 5'd2));
        stim_row(CMD_ADD,      8'h03, 32'h5, 32'h3, 4'h0, 1, 1'b0, '0);
        stim_row(CMD_DELETE,   8'h00, 32'h0, 32'h0, 4'hF, 1, 1'b1,
                 res_of(ST_BADPOS, 1'b0, 8'h00, 5'd0, 5'd3));
        stim_row(CMD_DELETE,   8'h00, 32'h0, 32'h0, 4'h2, 1, 1'b0, '0);
        stim_row(CMD_DELETE,   8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b0, '0);
        stim_row(CMD_ADD,      8'h55, 32'h0, 32'hAAAA_AAAA, 4'h0, 1, 1'b0, '0);
        stim_row(CMD_TICK,     8'h00, 32'h0, 32'h0, 4'h0, 2, 1'b0, '0);
        // two runs pending: one emitted, task reinserted with its period
        stim_row(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b0, '0);
        stim_row(CMD_CLEAR,    8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd0));
        stim_row(CMD_ADD,      8'hA5, 32'h7, 32'h1, 4'h0, MAX_ENTRIES, 1'b0, '0);
        stim_row(CMD_ADD,      8'h5A, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_FULL, 1'b0, 8'h00, 5'd16, 5'd16));
        stim_row(CMD_DELETE,   8'h00, 32'h0, 32'h0, 4'hF, 1, 1'b0, '0);
        stim_row(CMD_CLEAR,    8'h00, 32'h0, 32'h0, 4'h0, 1, 1'b1,
                 res_of(ST_OK, 1'b0, 8'h00, 5'd0, 5'd0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            for (int n = 0; n < stim_rows[r].reps; n++)
                send_cmd(stim_rows[r].item, $urandom_range(14, 0),
                         stim_rows[r].typed, stim_rows[r].res);
        end
        n_directed = n_transfers;

        // Random part; ignored command codes do not count
        counted = 0;
        k       = 0;
        mode    = MODE_FILL;
        quiet   = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (k % 40 == 0) mode = $urandom_range(MODE_DRAIN, MODE_MIXED);
            if (k % 60 == 0) quiet = ($urandom_range(2, 0) == 0);
            item = random_cmd(mode);
            send_cmd(item, quiet ? 0 : $urandom_range(14, 0), 1'b0, '0);
            if (item.command <= CMD_CLEAR) counted++;
            k++;
        end
        start <= 1'b0;

        // Drain, then let any late strobe show up
        waited = 0;
        while (pending_results.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("Covered %0d command transfers (%0d from the directed table).",
                 n_transfers, n_directed);
        $display("Checked %0d results: %0d task runs, %0d adds refused on a full list.",
                 n_results, n_runs, n_full);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // -------------------------------------------------------------- checking

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d handle %0h count %0d",
                       o_res.status, o_res.run_handle, o_res.task_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (o_res.run_valid === 1'b1) n_runs++;
                if (o_res.status === ST_FULL) n_full++;
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    errors++;
                end
                if (o_res.run_valid !== want.run_valid) begin
                    $error("run_valid: expected %0b, got %0b",
                           want.run_valid, o_res.run_valid);
                    errors++;
                end
                if (o_res.run_handle !== want.run_handle) begin
                    $error("run_handle: expected %0h, got %0h",
                           want.run_handle, o_res.run_handle);
                    errors++;
                end
                if (o_res.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want.slot_index, o_res.slot_index);
                    errors++;
                end
                if (o_res.task_count !== want.task_count) begin
                    $error("task_count: expected %0d, got %0d",
                           want.task_count, o_res.task_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

@@ delta_list_task_scheduler.f @@
src/dlts_pkg.sv
src/dlts_cell.sv
src/delta_list_task_scheduler.sv
tb/delta_list_task_scheduler_test.sv
